/* sv/line_rasterizer_with_padding_defines.svh */
// assertion macros used by the line rasterizer checker
`ifndef LINE_RASTERIZER_WITH_PADDING_DEFINES_SVH
`define LINE_RASTERIZER_WITH_PADDING_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define LRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lrp checker: same-cycle property failed");

// consequent must hold in the cycle after the antecedent
`define LRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lrp checker: next-cycle property failed");

`endif

/* sv/lrp_pkg.sv */
// shared constants and types of the line rasterizer
`default_nettype none

package lrp_pkg;

    // default coordinate width
    localparam int COORD_BITS_DEF = 16;

    // command codes
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // step phases of an advance: two filler pixels on a padded diagonal step, then the main pixel
    typedef enum logic [1:0] {
        PH_FILL_MAJOR,
        PH_FILL_MINOR,
        PH_MAIN
    } t_phase;

endpackage

`default_nettype wire

/* sv/lrp_cmd_if.sv */
// command channel: start or advance request with endpoints
`default_nettype none

interface lrp_cmd_if #(
    parameter int COORD_BITS = lrp_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic                         fill_diag;

    modport source (
        output valid, cmd, start_x, start_y, end_x, end_y, fill_diag,
        input  ready
    );

    modport sink (
        input  valid, cmd, start_x, start_y, end_x, end_y, fill_diag,
        output ready
    );
endinterface

`default_nettype wire

/* sv/lrp_point_if.sv */
// pixel channel: one rasterized point per transfer
`default_nettype none

interface lrp_point_if #(
    parameter int COORD_BITS = lrp_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         is_filler;
    logic                         last_point;

    modport source (
        output valid, point_x, point_y, is_filler, last_point,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_y, is_filler, last_point,
        output ready
    );
endinterface

`default_nettype wire

/* sv/lrp_setup.sv */
// line setup: spans, directions and major axis choice from two endpoints
`default_nettype none

module lrp_setup #(
    parameter int COORD_BITS = lrp_pkg::COORD_BITS_DEF
) (
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic                         o_swapped,
    output logic        [COORD_BITS-1:0] o_major_pos,
    output logic        [COORD_BITS-1:0] o_minor_pos,
    output logic        [COORD_BITS-1:0] o_major_end,
    output logic        [COORD_BITS:0]   o_major_span,
    output logic        [COORD_BITS:0]   o_minor_span,
    output logic        [1:0]            o_major_dir,
    output logic        [1:0]            o_minor_dir,
    output logic                         o_last
);

    logic signed [COORD_BITS:0] dcol;
    logic signed [COORD_BITS:0] drow;
    logic        [COORD_BITS:0] adcol;
    logic        [COORD_BITS:0] adrow;
    logic        [1:0]          dir_col;
    logic        [1:0]          dir_row;

    // endpoint differences, one bit wider so they never wrap
    assign dcol = $signed({i_end_x[COORD_BITS-1], i_end_x})
                - $signed({i_start_x[COORD_BITS-1], i_start_x});
    assign drow = $signed({i_end_y[COORD_BITS-1], i_end_y})
                - $signed({i_start_y[COORD_BITS-1], i_start_y});

    // magnitudes and step signs
    assign adcol   = dcol[COORD_BITS] ? -dcol : dcol;
    assign adrow   = drow[COORD_BITS] ? -drow : drow;
    assign dir_col = dcol[COORD_BITS] ? 2'b11 : ((dcol != '0) ? 2'b01 : 2'b00);
    assign dir_row = drow[COORD_BITS] ? 2'b11 : ((drow != '0) ? 2'b01 : 2'b00);

    // row axis becomes major only when strictly longer
    assign o_swapped = adrow > adcol;

    always_comb begin
        if (o_swapped) begin
            o_major_pos  = i_start_y;
            o_minor_pos  = i_start_x;
            o_major_end  = i_end_y;
            o_major_span = adrow;
            o_minor_span = adcol;
            o_major_dir  = dir_row;
            o_minor_dir  = dir_col;
        end else begin
            o_major_pos  = i_start_x;
            o_minor_pos  = i_start_y;
            o_major_end  = i_end_x;
            o_major_span = adcol;
            o_minor_span = adrow;
            o_major_dir  = dir_col;
            o_minor_dir  = dir_row;
        end
    end

    // zero-length line ends on its first pixel
    assign o_last = (o_major_pos == o_major_end);

endmodule

`default_nettype wire

/* sv/line_rasterizer_with_padding.sv */
// Bresenham line rasterizer for all octants with optional 4-connected padding
//
// Channels: i_cmd takes start and advance commands, o_pt gives pixels, both
// valid/ready, a transfer at each rising edge with valid and ready high.
// A start loads the endpoints and the padding flag and gives the first pixel.
// Each advance runs one error step and gives the next pixel; with padding on,
// a diagonal step gives two filler pixels first (one result per cycle while
// the output register is free, in phases PH_FILL_MAJOR, PH_FILL_MINOR and
// PH_MAIN). The endpoint pixel carries last_point. An advance while no line
// is active gives nothing. A command passes the input register and then the
// output register before its first pixel shows on o_pt. Throughput: one
// pixel per cycle unless stalled; set by the single-pixel output register,
// which is loaded in the same cycle that the receiver takes the old pixel.
// Reset (synchronous, active low) leaves the block idle with empty stages.
// When the receiver stalls, the pixel holds in the output register, the step
// logic waits and one more command waits in the input register.
`default_nettype none

module line_rasterizer_with_padding #(
    parameter int COORD_BITS = lrp_pkg::COORD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lrp_cmd_if.sink    i_cmd,
    lrp_point_if.source o_pt
);

    localparam int ERR_W = COORD_BITS + 3;

    // input register
    logic                         r_in_valid;
    logic                         r_in_cmd;
    logic signed [COORD_BITS-1:0] r_in_sx;
    logic signed [COORD_BITS-1:0] r_in_sy;
    logic signed [COORD_BITS-1:0] r_in_ex;
    logic signed [COORD_BITS-1:0] r_in_ey;
    logic                         r_in_pad;

    // line state
    logic        [COORD_BITS-1:0] r_major_pos;
    logic        [COORD_BITS-1:0] r_minor_pos;
    logic        [COORD_BITS-1:0] r_major_end;
    logic signed [ERR_W-1:0]      r_err;
    logic        [COORD_BITS:0]   r_major_span;
    logic        [COORD_BITS:0]   r_minor_span;
    logic        [1:0]            r_major_dir;
    logic        [1:0]            r_minor_dir;
    logic                         r_swapped;
    logic                         r_pad_on;
    logic                         r_active;
    lrp_pkg::t_phase              r_phase;
    lrp_pkg::t_phase              n_phase;

    // output register
    logic                         r_out_valid;
    logic        [COORD_BITS-1:0] r_out_x;
    logic        [COORD_BITS-1:0] r_out_y;
    logic                         r_out_filler;
    logic                         r_out_last;

    // setup results
    logic                         su_swapped;
    logic        [COORD_BITS-1:0] su_major_pos;
    logic        [COORD_BITS-1:0] su_minor_pos;
    logic        [COORD_BITS-1:0] su_major_end;
    logic        [COORD_BITS:0]   su_major_span;
    logic        [COORD_BITS:0]   su_minor_span;
    logic        [1:0]            su_major_dir;
    logic        [1:0]            su_minor_dir;
    logic                         su_last;

    // step datapath
    logic signed [ERR_W-1:0]      e_sum;
    logic signed [ERR_W-1:0]      e_next;
    logic                         diag;
    logic                         pad_diag;
    logic        [COORD_BITS-1:0] maj_step;
    logic        [COORD_BITS-1:0] min_step;
    logic        [COORD_BITS-1:0] min_next;
    logic                         last_adv;

    // control
    logic                         take_in;
    logic                         out_free;
    logic                         done;
    logic                         out_load;
    logic                         start_commit;
    logic                         adv_commit;
    logic        [COORD_BITS-1:0] res_major;
    logic        [COORD_BITS-1:0] res_minor;
    logic                         res_swapped;
    logic                         res_filler;
    logic                         res_last;

    lrp_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .i_start_x    (r_in_sx),
        .i_start_y    (r_in_sy),
        .i_end_x      (r_in_ex),
        .i_end_y      (r_in_ey),
        .o_swapped    (su_swapped),
        .o_major_pos  (su_major_pos),
        .o_minor_pos  (su_minor_pos),
        .o_major_end  (su_major_end),
        .o_major_span (su_major_span),
        .o_minor_span (su_minor_span),
        .o_major_dir  (su_major_dir),
        .o_minor_dir  (su_minor_dir),
        .o_last       (su_last)
    );

    // handshakes
    assign i_cmd.ready = !r_in_valid || done;
    assign take_in     = i_cmd.valid && i_cmd.ready;
    assign out_free    = !r_out_valid || o_pt.ready;

    // error step and neighbor positions
    assign e_sum    = r_err + $signed({1'b0, r_minor_span, 1'b0});
    assign diag     = !e_sum[ERR_W-1] && (e_sum != '0);
    assign e_next   = diag ? e_sum - $signed({1'b0, r_major_span, 1'b0}) : e_sum;
    assign pad_diag = r_pad_on && diag;
    assign maj_step = r_major_pos + {{(COORD_BITS-2){r_major_dir[1]}}, r_major_dir};
    assign min_step = r_minor_pos + {{(COORD_BITS-2){r_minor_dir[1]}}, r_minor_dir};
    assign min_next = diag ? min_step : r_minor_pos;
    assign last_adv = (maj_step == r_major_end);

    // phase sequencing and result selection
    always_comb begin
        n_phase      = r_phase;
        done         = 1'b0;
        out_load     = 1'b0;
        start_commit = 1'b0;
        adv_commit   = 1'b0;
        res_major    = maj_step;
        res_minor    = min_next;
        res_swapped  = r_swapped;
        res_filler   = 1'b0;
        res_last     = last_adv;
        if (r_in_valid) begin
            if (r_in_cmd == lrp_pkg::CMD_START) begin
                res_major   = su_major_pos;
                res_minor   = su_minor_pos;
                res_swapped = su_swapped;
                res_last    = su_last;
                if (out_free) begin
                    out_load     = 1'b1;
                    done         = 1'b1;
                    start_commit = 1'b1;
                    n_phase      = lrp_pkg::PH_FILL_MAJOR;
                end
            end else if (!r_active) begin
                // advance with no line: consumed silently
                done = 1'b1;
            end else if (out_free) begin
                out_load = 1'b1;
                case (r_phase)
                    lrp_pkg::PH_FILL_MAJOR: begin
                        if (pad_diag) begin
                            res_minor  = r_minor_pos;
                            res_filler = 1'b1;
                            res_last   = 1'b0;
                            n_phase    = lrp_pkg::PH_FILL_MINOR;
                        end else begin
                            done       = 1'b1;
                            adv_commit = 1'b1;
                        end
                    end
                    lrp_pkg::PH_FILL_MINOR: begin
                        res_major  = r_major_pos;
                        res_minor  = min_step;
                        res_filler = 1'b1;
                        res_last   = 1'b0;
                        n_phase    = lrp_pkg::PH_MAIN;
                    end
                    lrp_pkg::PH_MAIN: begin
                        done       = 1'b1;
                        adv_commit = 1'b1;
                        n_phase    = lrp_pkg::PH_FILL_MAJOR;
                    end
                    default: begin
                        out_load = 1'b0;
                        n_phase  = lrp_pkg::PH_FILL_MAJOR;
                    end
                endcase
            end
        end
    end

    // phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lrp_pkg::PH_FILL_MAJOR;
        end else begin
            r_phase <= n_phase;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in_cmd <= i_cmd.cmd;
            r_in_sx  <= i_cmd.start_x;
            r_in_sy  <= i_cmd.start_y;
            r_in_ex  <= i_cmd.end_x;
            r_in_ey  <= i_cmd.end_y;
            r_in_pad <= i_cmd.fill_diag;
        end
    end

    // line state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major_pos  <= '0;
            r_minor_pos  <= '0;
            r_major_end  <= '0;
            r_err        <= '0;
            r_major_span <= '0;
            r_minor_span <= '0;
            r_major_dir  <= '0;
            r_minor_dir  <= '0;
            r_swapped    <= 1'b0;
            r_pad_on     <= 1'b0;
            r_active     <= 1'b0;
        end else if (start_commit) begin
            r_major_pos  <= su_major_pos;
            r_minor_pos  <= su_minor_pos;
            r_major_end  <= su_major_end;
            r_err        <= -$signed({2'b00, su_major_span});
            r_major_span <= su_major_span;
            r_minor_span <= su_minor_span;
            r_major_dir  <= su_major_dir;
            r_minor_dir  <= su_minor_dir;
            r_swapped    <= su_swapped;
            r_pad_on     <= r_in_pad;
            r_active     <= !su_last;
        end else if (adv_commit) begin
            r_major_pos <= maj_step;
            r_minor_pos <= min_next;
            r_err       <= e_next;
            r_active    <= !last_adv;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_pt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_x      <= res_swapped ? res_minor : res_major;
            r_out_y      <= res_swapped ? res_major : res_minor;
            r_out_filler <= res_filler;
            r_out_last   <= res_last;
        end
    end

    assign o_pt.valid      = r_out_valid;
    assign o_pt.point_x    = r_out_x;
    assign o_pt.point_y    = r_out_y;
    assign o_pt.is_filler  = r_out_filler;
    assign o_pt.last_point = r_out_last;

endmodule

`default_nettype wire

/* sv/lrp_checker.sv */
// port-level checks of the line rasterizer, bound to the top level
`default_nettype none
`include "line_rasterizer_with_padding_defines.svh"

module lrp_checker #(
    parameter int COORD_BITS = lrp_pkg::COORD_BITS_DEF
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_out_valid,
    input wire logic                  i_out_ready,
    input wire logic [COORD_BITS-1:0] i_out_x,
    input wire logic [COORD_BITS-1:0] i_out_y,
    input wire logic                  i_out_filler,
    input wire logic                  i_out_last
);

    // a stalled pixel stays offered
    `LRP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // a stalled pixel keeps its payload
    `LRP_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_x) && $stable(i_out_y) && $stable(i_out_filler) && $stable(i_out_last))

    // filler pixels never close a line
    `LRP_ASSERT_NOW(a_filler_not_last, i_clk, i_rst_n, i_out_valid && i_out_filler, !i_out_last)

    // a filler transfer is always followed at once by the rest of its step
    `LRP_ASSERT_NEXT(a_filler_follow, i_clk, i_rst_n, i_out_valid && i_out_ready && i_out_filler, i_out_valid)

endmodule

bind line_rasterizer_with_padding lrp_checker #(
    .COORD_BITS (COORD_BITS)
) u_lrp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_pt.valid),
    .i_out_ready  (o_pt.ready),
    .i_out_x      (o_pt.point_x),
    .i_out_y      (o_pt.point_y),
    .i_out_filler (o_pt.is_filler),
    .i_out_last   (o_pt.last_point)
);

`default_nettype wire

/* bench/line_rasterizer_with_padding_tb.sv */
// testbench for the line rasterizer: directed and random lines checked pixel by pixel
`timescale 1ns / 1ps

module line_rasterizer_with_padding_tb;

    localparam int CB          = lrp_pkg::COORD_BITS_DEF;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic                 cmd;
        logic signed [CB-1:0] start_x;
        logic signed [CB-1:0] start_y;
        logic signed [CB-1:0] end_x;
        logic signed [CB-1:0] end_y;
        logic                 fill_diag;
    } t_line_cmd;

    typedef struct packed {
        logic signed [CB-1:0] point_x;
        logic signed [CB-1:0] point_y;
        logic                 is_filler;
        logic                 last_point;
    } t_pixel;

    logic i_clk;
    logic i_rst_n;

    lrp_cmd_if   #(.COORD_BITS(CB)) cmd_if ();
    lrp_point_if #(.COORD_BITS(CB)) pt_if ();

    line_rasterizer_with_padding #(.COORD_BITS(CB)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_pt    (pt_if)
    );

    t_pixel expected_pixels[$];
    int     mismatch_count = 0;
    int     cmds_sent      = 0;
    int     cycle_count    = 0;
    int     tx_idle_pct    = 0;
    int     rx_idle_pct    = 0;
    int     stall_request  = 0;
    int     stall_left     = 0;

    // rasterizer state as the block should hold it
    int ras_major, ras_minor, ras_major_end, ras_err;
    int ras_major_span, ras_minor_span, ras_major_dir, ras_minor_dir;
    bit ras_swapped, ras_pad, ras_active;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // pixel receiver: random stalls plus a long hold-off on request
    always @(posedge i_clk) begin
        if (stall_request > 0) begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            pt_if.ready <= 1'b0;
        end else begin
            pt_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic int iabs(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int idir(int v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // queue one pixel, mapping major/minor back to column/row
    function automatic void push_pixel(int maj, int mnr, bit filler, bit last);
        t_pixel pix;
        int     col;
        int     row;
        col = ras_swapped ? mnr : maj;
        row = ras_swapped ? maj : mnr;
        pix.point_x    = col[CB-1:0];
        pix.point_y    = row[CB-1:0];
        pix.is_filler  = filler;
        pix.last_point = last;
        expected_pixels.insert(expected_pixels.size(), pix);
    endfunction

    // pixels produced by one accepted command
    function automatic void rasterize_cmd(t_line_cmd c);
        int dcol;
        int drow;
        bit last;
        if (c.cmd == lrp_pkg::CMD_START) begin
            dcol        = int'(c.end_x) - int'(c.start_x);
            drow        = int'(c.end_y) - int'(c.start_y);
            ras_swapped = iabs(drow) > iabs(dcol);
            if (ras_swapped) begin
                ras_major      = int'(c.start_y);
                ras_minor      = int'(c.start_x);
                ras_major_end  = int'(c.end_y);
                ras_major_span = iabs(drow);
                ras_minor_span = iabs(dcol);
                ras_major_dir  = idir(drow);
                ras_minor_dir  = idir(dcol);
            end else begin
                ras_major      = int'(c.start_x);
                ras_minor      = int'(c.start_y);
                ras_major_end  = int'(c.end_x);
                ras_major_span = iabs(dcol);
                ras_minor_span = iabs(drow);
                ras_major_dir  = idir(dcol);
                ras_minor_dir  = idir(drow);
            end
            ras_pad    = c.fill_diag;
            ras_err    = -ras_major_span;
            last       = (ras_major == ras_major_end);
            push_pixel(ras_major, ras_minor, 1'b0, last);
            ras_active = !last;
            return;
        end
        // advance with no active line does nothing
        if (!ras_active)
            return;
        ras_err += 2 * ras_minor_span;
        if (ras_err > 0) begin
            if (ras_pad) begin
                push_pixel(ras_major + ras_major_dir, ras_minor, 1'b1, 1'b0);
                push_pixel(ras_major, ras_minor + ras_minor_dir, 1'b1, 1'b0);
            end
            ras_minor += ras_minor_dir;
            ras_err   -= 2 * ras_major_span;
        end
        ras_major += ras_major_dir;
        last       = (ras_major == ras_major_end);
        push_pixel(ras_major, ras_minor, 1'b0, last);
        ras_active = !last;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // pixel checker
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && pt_if.valid === 1'b1 && pt_if.ready === 1'b1) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected pixel, expected none, actual (%0d,%0d) f=%0b l=%0b",
                         $time, pt_if.point_x, pt_if.point_y, pt_if.is_filler,
                         pt_if.last_point);
                mismatch_count++;
            end else begin
                want = expected_pixels.pop_front();
                check_field("point_x", want.point_x, pt_if.point_x);
                check_field("point_y", want.point_y, pt_if.point_y);
                check_field("is_filler", want.is_filler, pt_if.is_filler);
                check_field("last_point", want.last_point, pt_if.last_point);
            end
        end
    end

    // offer one command and wait for its transfer; called at a rising edge
    task automatic send_cmd(t_line_cmd c);
        while ($urandom_range(99) < tx_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.cmd       <= c.cmd;
        cmd_if.start_x   <= c.start_x;
        cmd_if.start_y   <= c.start_y;
        cmd_if.end_x     <= c.end_x;
        cmd_if.end_y     <= c.end_y;
        cmd_if.fill_diag <= c.fill_diag;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
        rasterize_cmd(c);
        cmds_sent++;
    endtask

    task automatic send_start(int sx, int sy, int ex, int ey, bit pad);
        t_line_cmd c;
        c.cmd       = lrp_pkg::CMD_START;
        c.start_x   = sx[CB-1:0];
        c.start_y   = sy[CB-1:0];
        c.end_x     = ex[CB-1:0];
        c.end_y     = ey[CB-1:0];
        c.fill_diag = pad;
        send_cmd(c);
    endtask

    // endpoint fields carry junk on an advance
    task automatic send_advance();
        t_line_cmd   c;
        logic [95:0] junk;
        junk  = {$urandom, $urandom, $urandom};
        c     = junk[$bits(t_line_cmd)-1:0];
        c.cmd = lrp_pkg::CMD_ADVANCE;
        send_cmd(c);
    endtask

    task automatic wait_for_pixels();
        cmd_if.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic test_idle_advance();
        send_advance();
        send_advance();
        wait_for_pixels();
    endtask

    // zero length, shallow, steep negative and plain diagonal lines
    task automatic test_short_lines();
        send_start(3, 3, 3, 3, 1'b1);
        send_start(0, 0, 3, 1, 1'b1);
        repeat (3) send_advance();
        send_start(5, 5, 3, 0, 1'b1);
        repeat (5) send_advance();
        send_start(-2, 4, 1, 1, 1'b0);
        repeat (3) send_advance();
        // advance past the endpoint
        send_advance();
        wait_for_pixels();
    endtask

    // full-range endpoints, restart while a line is active
    task automatic test_extreme_lines();
        send_start(-32768, -32768, 32767, 32767, 1'b1);
        send_advance();
        send_start(32767, -32768, -32768, 32767, 1'b0);
        send_advance();
        send_start(32767, 32767, 32767, 32764, 1'b1);
        repeat (3) send_advance();
        wait_for_pixels();
    endtask

    // one random line: mostly complete short lines, some noise and wide lines
    task automatic random_line();
        int kind;
        int sx;
        int sy;
        int dx;
        int dy;
        int steps;
        kind = $urandom_range(99);
        if (kind < 8) begin
            send_advance();
        end else if (kind < 14) begin
            send_start($urandom, $urandom, $urandom, $urandom, $urandom_range(1));
            repeat ($urandom_range(4)) send_advance();
        end else begin
            sx    = int'($urandom_range(65471)) - 32736;
            sy    = int'($urandom_range(65471)) - 32736;
            dx    = int'($urandom_range(24)) - 12;
            dy    = int'($urandom_range(24)) - 12;
            steps = (iabs(dx) > iabs(dy)) ? iabs(dx) : iabs(dy);
            case ($urandom_range(9))
                0: steps = $urandom_range(steps);
                1: steps += $urandom_range(1, 2);
                default: ;
            endcase
            send_start(sx, sy, sx + dx, sy + dy, $urandom_range(1));
            repeat (steps) send_advance();
        end
    endtask

    task automatic test_random_lines(int target, int tx_pct, int rx_pct);
        int first;
        first       = cmds_sent;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (cmds_sent - first < target)
            random_line();
        wait_for_pixels();
    endtask

    // receiver holds off while commands keep coming, so the input stalls
    task automatic test_output_stall();
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        stall_request = 150;
        send_start(10, -10, 22, -2, 1'b1);
        repeat (12) send_advance();
        send_start(-7, 3, -1, 14, 1'b1);
        repeat (11) send_advance();
        wait_for_pixels();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        cmd_if.valid     = 1'b0;
        cmd_if.cmd       = lrp_pkg::CMD_START;
        cmd_if.start_x   = '0;
        cmd_if.start_y   = '0;
        cmd_if.end_x     = '0;
        cmd_if.end_y     = '0;
        cmd_if.fill_diag = 1'b0;
        pt_if.ready      = 1'b0;
        ras_major = 0; ras_minor = 0; ras_major_end = 0; ras_err = 0;
        ras_major_span = 0; ras_minor_span = 0; ras_major_dir = 0; ras_minor_dir = 0;
        ras_swapped = 1'b0; ras_pad = 1'b0; ras_active = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_advance();
        test_short_lines();
        test_extreme_lines();
        test_random_lines(125, 18, 72);
        test_random_lines(125, 72, 18);
        test_random_lines(115, 0, 0);
        test_output_stall();

        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
